/* src/hnv_pkg.sv */
// hnv_pkg: types and constants shared by the host name validator.
// No dependencies; compiled first.
`default_nettype none

package hnv_pkg;

  // Character codes
  localparam logic [7:0] CH_HYPHEN = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;

  // Label limits: count saturates one above the largest legal label
  localparam int unsigned LABEL_W = 7;
  localparam logic [LABEL_W-1:0] LABEL_MAX = 7'd63;
  localparam logic [LABEL_W-1:0] LABEL_SAT = 7'd64;

  // Dotted IPv4 limits
  localparam int unsigned IPV4_MIN_BYTES = 7;
  localparam int unsigned IPV4_MAX_BYTES = 15;
  localparam logic [9:0]  OCTET_MAX      = 10'd255;
  localparam logic [1:0]  OCTET_DIGITS   = 2'd3;
  localparam logic [1:0]  LAST_OCTET     = 2'd3;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
    logic       empty_name;
  } item_t;

  typedef struct packed {
    logic host_valid;
    logic as_ipv4;
  } verdict_t;

endpackage

`default_nettype wire

/* src/hnv_if.sv */
// hnv_if: valid/ready channel interfaces for name bytes and verdicts.
// No dependencies.
`default_nettype none

interface hnv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_byte;
  logic       empty_name;

  modport source (output valid, char_byte, last_byte, empty_name, input ready);
  modport sink   (input valid, char_byte, last_byte, empty_name, output ready);
endinterface

interface hnv_verdict_if;
  logic valid;
  logic ready;
  logic host_valid;
  logic as_ipv4;

  modport source (output valid, host_valid, as_ipv4, input ready);
  modport sink   (input valid, host_valid, as_ipv4, output ready);
endinterface

`default_nettype wire

/* src/hnv_in_reg.sv */
// hnv_in_reg: input register holding one byte item ahead of the scan logic.
// Depends on hnv_pkg.
`default_nettype none

module hnv_in_reg
  import hnv_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire item_t in_item,
  output logic       in_ready,
  input  wire logic  res_free,
  output logic       step,
  output item_t      item
);

  logic held;

  // Items that end a name need a free result slot; others always move on.
  assign step     = held && (!item.last_byte || res_free);
  assign in_ready = !held || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

/* src/hnv_scan.sv */
// hnv_scan: per-name counters and flags, mode register and verdict logic.
// Depends on hnv_pkg.
`default_nettype none

module hnv_scan
  import hnv_pkg::*;
#(
  parameter int unsigned MAX_NAME_BYTES = 255
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  host_mode_we,
  input  wire logic  host_mode_wdata,
  input  wire logic  step,
  input  wire item_t item,
  output logic       res_valid,
  output verdict_t   res
);

  localparam int unsigned NW = $clog2(MAX_NAME_BYTES + 2);
  localparam logic [NW-1:0] NAME_MAX  = NW'(MAX_NAME_BYTES);
  localparam logic [NW-1:0] IPV4_MIN  = NW'(IPV4_MIN_BYTES);
  localparam logic [NW-1:0] IPV4_MAX  = NW'(IPV4_MAX_BYTES);

  logic                host_mode;
  logic [NW-1:0]       name_count,  name_count_next;
  logic [LABEL_W-1:0]  label_count, label_count_next;
  logic [7:0]          previous_byte, previous_byte_next;
  logic                label_begins_hyphen, label_begins_hyphen_next;
  logic                dns_failed, dns_failed_next;
  logic                saw_dot, saw_dot_next;
  logic                digits_dots_only, digits_dots_only_next;
  logic [1:0]          octet_number, octet_number_next;
  logic [1:0]          octet_digit_count, octet_digit_count_next;
  logic [9:0]          octet_value, octet_value_next;
  logic                octet_leading_zero, octet_leading_zero_next;
  logic                ipv4_failed, ipv4_failed_next;

  logic [7:0] c;
  logic       is_dot, is_digit, is_lower, is_hyphen;
  logic       label_ok, octet_ok, label_ok_end, octet_ok_end;
  logic       dns_ok, ip_ok, numeric;

  assign c         = item.char_byte;
  assign is_dot    = (c == CH_DOT);
  assign is_hyphen = (c == CH_HYPHEN);
  assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_lower  = (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);

  // Label / octet checks on the state before this byte (used at a dot)
  assign label_ok = (label_count != '0) && (label_count <= LABEL_MAX) &&
                    !label_begins_hyphen && (previous_byte != CH_HYPHEN);
  assign octet_ok = (octet_digit_count != 2'd0) && (octet_value <= OCTET_MAX) &&
                    !((octet_digit_count > 2'd1) && octet_leading_zero);

  always_comb begin
    name_count_next          = name_count;
    label_count_next         = label_count;
    label_begins_hyphen_next = label_begins_hyphen;
    dns_failed_next          = dns_failed;
    saw_dot_next             = saw_dot;
    digits_dots_only_next    = digits_dots_only;
    octet_number_next        = octet_number;
    octet_digit_count_next   = octet_digit_count;
    octet_value_next         = octet_value;
    octet_leading_zero_next  = octet_leading_zero;
    ipv4_failed_next         = ipv4_failed;
    previous_byte_next       = c;

    if (name_count <= NAME_MAX) begin
      name_count_next = name_count + 1'b1;
    end

    if (is_dot) begin
      saw_dot_next = 1'b1;
      if (!label_ok) begin
        dns_failed_next = 1'b1;
      end
      label_count_next         = '0;
      label_begins_hyphen_next = 1'b0;
      if (!octet_ok || (octet_number == LAST_OCTET)) begin
        ipv4_failed_next = 1'b1;
      end else begin
        octet_number_next = octet_number + 2'd1;
      end
      octet_digit_count_next  = 2'd0;
      octet_value_next        = 10'd0;
      octet_leading_zero_next = 1'b0;
    end else begin
      if (!is_lower && !is_digit && !is_hyphen) begin
        dns_failed_next = 1'b1;
      end
      if (label_count == '0) begin
        label_begins_hyphen_next = is_hyphen;
      end
      if (label_count < LABEL_SAT) begin
        label_count_next = label_count + 1'b1;
      end
      if (is_digit) begin
        if (octet_digit_count == OCTET_DIGITS) begin
          ipv4_failed_next = 1'b1;
        end else begin
          if (octet_digit_count == 2'd0) begin
            octet_leading_zero_next = (c == CH_ZERO);
          end
          // value*10 + digit; at most two digits held, so it stays below 1000
          octet_value_next = (octet_value << 3) + (octet_value << 1) +
                             {6'd0, c[3:0]};
          octet_digit_count_next = octet_digit_count + 2'd1;
        end
      end else begin
        digits_dots_only_next = 1'b0;
      end
    end
  end

  // Verdict on the state after the final byte
  assign label_ok_end = (label_count_next != '0) && (label_count_next <= LABEL_MAX) &&
                        !label_begins_hyphen_next && (previous_byte_next != CH_HYPHEN);
  assign octet_ok_end = (octet_digit_count_next != 2'd0) &&
                        (octet_value_next <= OCTET_MAX) &&
                        !((octet_digit_count_next > 2'd1) && octet_leading_zero_next);
  assign dns_ok  = !dns_failed_next && label_ok_end && (name_count_next <= NAME_MAX) &&
                   (previous_byte_next != CH_DOT);
  assign ip_ok   = !ipv4_failed_next && octet_ok_end && (octet_number_next == LAST_OCTET) &&
                   (name_count_next >= IPV4_MIN) && (name_count_next <= IPV4_MAX);
  assign numeric = digits_dots_only_next && saw_dot_next;

  assign res_valid = step && item.last_byte;

  always_comb begin
    res = '0;
    if (!item.empty_name) begin
      if (!host_mode) begin
        res.host_valid = dns_ok && !numeric;
      end else if (numeric) begin
        res.host_valid = ip_ok;
        res.as_ipv4    = 1'b1;
      end else begin
        res.host_valid = dns_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      host_mode <= 1'b0;
    end else if (host_mode_we) begin
      host_mode <= host_mode_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      name_count          <= '0;
      label_count         <= '0;
      previous_byte       <= 8'd0;
      label_begins_hyphen <= 1'b0;
      dns_failed          <= 1'b0;
      saw_dot             <= 1'b0;
      digits_dots_only    <= 1'b1;
      octet_number        <= 2'd0;
      octet_digit_count   <= 2'd0;
      octet_value         <= 10'd0;
      octet_leading_zero  <= 1'b0;
      ipv4_failed         <= 1'b0;
    end else if (step && !item.empty_name) begin
      name_count          <= name_count_next;
      label_count         <= label_count_next;
      previous_byte       <= previous_byte_next;
      label_begins_hyphen <= label_begins_hyphen_next;
      dns_failed          <= dns_failed_next;
      saw_dot             <= saw_dot_next;
      digits_dots_only    <= digits_dots_only_next;
      octet_number        <= octet_number_next;
      octet_digit_count   <= octet_digit_count_next;
      octet_value         <= octet_value_next;
      octet_leading_zero  <= octet_leading_zero_next;
      ipv4_failed         <= ipv4_failed_next;
    end
  end

endmodule

`default_nettype wire

/* src/hnv_out_reg.sv */
// hnv_out_reg: result register in front of the verdict channel.
// Depends on hnv_pkg.
`default_nettype none

module hnv_out_reg
  import hnv_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     res_valid,
  input  wire verdict_t res,
  output logic          res_free,
  output logic          out_valid,
  input  wire logic     out_ready,
  output verdict_t      out_res
);

  assign res_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res_valid) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

/* src/host_name_validator_top.sv */
// host_name_validator_top: streaming host name validator, top level.
// Depends on hnv_pkg, hnv_if, hnv_in_reg, hnv_scan and hnv_out_reg.
//
// Takes a host name one byte per transfer on byte_chan (last_byte marks the
// final byte; empty_name with last_byte marks a zero-length name) and gives
// one verdict transfer per name on verdict_chan. host_mode 0 accepts only
// canonical DNS names (lower-case, digits, hyphen, labels 1..63 bytes, no
// edge hyphens, no trailing dot, at most MAX_NAME_BYTES bytes) and rejects
// all-digits-and-dots names; host_mode 1 checks such names as canonical
// dotted IPv4 instead and flags that with as_ipv4. Throughput is one byte
// per clock while no final byte is held back; each byte is settled while
// it sits in the input register, the per-name counters being updated by
// plain compares and one shift-add. The verdict is registered: the final
// byte passes the input register and then the result register before
// its verdict is shown. The input stalls only while a verdict
// is held unread and the next final byte is waiting behind it; non-final
// bytes pass even then. A stray empty_name without last_byte is taken and
// ignored. host_mode is written through host_mode_we/host_mode_wdata and
// should only change while no name is in progress. No clearing pass is
// needed after reset.
`default_nettype none

module host_name_validator_top
  import hnv_pkg::*;
#(
  parameter int unsigned MAX_NAME_BYTES = 255
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     host_mode_we,
  input  wire logic     host_mode_wdata,
  hnv_byte_if.sink      byte_chan,
  hnv_verdict_if.source verdict_chan
);

  item_t    in_item;
  item_t    item;
  logic     step;
  logic     res_valid;
  logic     res_free;
  verdict_t res;
  verdict_t out_res;

  assign in_item.char_byte  = byte_chan.char_byte;
  assign in_item.last_byte  = byte_chan.last_byte;
  assign in_item.empty_name = byte_chan.empty_name;

  // Input register: one item waiting to be scanned
  hnv_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_chan.valid),
    .in_item  (in_item),
    .in_ready (byte_chan.ready),
    .res_free (res_free),
    .step     (step),
    .item     (item)
  );

  // Per-name state and verdict
  hnv_scan #(
    .MAX_NAME_BYTES (MAX_NAME_BYTES)
  ) u_scan (
    .clk             (clk),
    .rst             (rst),
    .host_mode_we    (host_mode_we),
    .host_mode_wdata (host_mode_wdata),
    .step            (step),
    .item            (item),
    .res_valid       (res_valid),
    .res             (res)
  );

  // Result register towards the verdict channel
  hnv_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_free  (res_free),
    .out_valid (verdict_chan.valid),
    .out_ready (verdict_chan.ready),
    .out_res   (out_res)
  );

  assign verdict_chan.host_valid = out_res.host_valid;
  assign verdict_chan.as_ipv4    = out_res.as_ipv4;

endmodule

`default_nettype wire

/* src/hnv_checker.sv */
// hnv_checker: port-level assertions for host_name_validator_top, and bind.
// Depends on host_name_validator_top.
`default_nettype none

module hnv_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic host_mode_we,
  input wire logic host_mode_wdata,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_host_valid,
  input wire logic out_as_ipv4
);

  logic mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (host_mode_we) begin
      mode <= host_mode_wdata;
    end
  end

  // A stalled verdict holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_host_valid) && $stable(out_as_ipv4))
    else $error("verdict changed while stalled");

  // Input only backs up behind an unread verdict
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with verdict channel free");

  // IPv4 verdicts only in logical mode
  a_ipv4_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_as_ipv4 |-> mode)
    else $error("as_ipv4 in strict DNS mode");

  // No verdict straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("verdict shown after reset");

endmodule

bind host_name_validator_top hnv_checker u_hnv_checker (
  .clk             (clk),
  .rst             (rst),
  .host_mode_we    (host_mode_we),
  .host_mode_wdata (host_mode_wdata),
  .in_ready        (byte_chan.ready),
  .out_valid       (verdict_chan.valid),
  .out_ready       (verdict_chan.ready),
  .out_host_valid  (verdict_chan.host_valid),
  .out_as_ipv4     (verdict_chan.as_ipv4)
);

`default_nettype wire
